[rtl/cldf_pkg.sv]
// ----------------------------------------------------------------------------
// cldf_pkg
// Shared types, codes and the byte-wise CRC-32 update for the length-prefixed
// frame deframer.
// ----------------------------------------------------------------------------
package cldf_pkg;

    localparam logic [7:0]  START_BYTE      = 8'h24;
    localparam logic [31:0] CRC_POLY        = 32'hEDB8_8320;
    localparam logic [31:0] CRC_INIT        = 32'hFFFF_FFFF;
    localparam logic [23:0] LEN_SAT         = 24'hFF_FFFF;
    localparam logic [23:0] MAX_LEN_RESET   = 24'd65536;

    localparam logic [1:0]  PH_HUNT         = 2'd0;
    localparam logic [1:0]  PH_LEN          = 2'd1;
    localparam logic [1:0]  PH_DATA         = 2'd2;
    localparam logic [1:0]  PH_CRC          = 2'd3;

    localparam logic [1:0]  LANE_LAST       = 2'd3;

    localparam logic [2:0]  KIND_PAYLOAD    = 3'd0;
    localparam logic [2:0]  KIND_GOOD       = 3'd1;
    localparam logic [2:0]  KIND_BAD_CRC    = 3'd2;
    localparam logic [2:0]  KIND_OVERSIZE   = 3'd3;
    localparam logic [2:0]  KIND_STRAY      = 3'd4;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  data;
        logic [23:0] frame_length;
        logic [31:0] computed_crc;
    } result_t;

    typedef struct packed {
        logic    emit;
        result_t res;
    } engine_out_t;

    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

[rtl/cldf_channels.sv]
// ----------------------------------------------------------------------------
// cldf channel interfaces
// Valid/ready channels for received bytes, results and the config write.
// ----------------------------------------------------------------------------
interface cldf_rx_if
    import cldf_pkg::*;
();
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface cldf_res_if
    import cldf_pkg::*;
();
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [7:0]  data;
    logic [23:0] frame_length;
    logic [31:0] computed_crc;

    modport source (output valid, output kind, output data, output frame_length,
                    output computed_crc, input ready);
    modport sink   (input valid, input kind, input data, input frame_length,
                    input computed_crc, output ready);
endinterface

interface cldf_cfg_if
    import cldf_pkg::*;
();
    logic        valid;
    logic        ready;
    logic [23:0] max_payload_length;

    modport source (output valid, output max_payload_length, input ready);
    modport sink   (input valid, input max_payload_length, output ready);
endinterface

[rtl/cldf_engine.sv]
// ----------------------------------------------------------------------------
// cldf_engine
// Frame parser state and per-beat CRC update; one byte per enabled cycle.
// ----------------------------------------------------------------------------
module cldf_engine
    import cldf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        step,
    input  logic [7:0]  rx_byte,
    input  logic [23:0] max_len,
    output engine_out_t eout
);

    logic [1:0]  phase_reg, phase_next;
    logic [23:0] count_reg, count_next;
    logic [23:0] len_reg,   len_next;
    logic [31:0] crc_reg,   crc_next;
    logic [23:0] rcrc_reg,  rcrc_next;

    logic [31:0] crc_upd;
    logic [1:0]  lane;
    logic [31:0] full_len;
    logic [23:0] sat_len;
    logic [31:0] full_rcrc;
    logic [23:0] count_inc;

    assign crc_upd   = crc_byte(crc_reg, rx_byte);
    assign lane      = count_reg[1:0];
    assign full_len  = {rx_byte, len_reg};
    assign sat_len   = (full_len[31:24] != 8'd0) ? LEN_SAT : full_len[23:0];
    assign full_rcrc = {rx_byte, rcrc_reg};
    assign count_inc = count_reg + 24'd1;

    always_comb
    begin
        phase_next = phase_reg;
        count_next = count_reg;
        len_next   = len_reg;
        crc_next   = crc_reg;
        rcrc_next  = rcrc_reg;
        eout       = '0;
        unique case (phase_reg)
            PH_LEN:
            begin
                crc_next = crc_upd;
                if (lane != LANE_LAST)
                begin
                    count_next = count_inc;
                    case (lane)
                        2'd0:    len_next[7:0]   = rx_byte;
                        2'd1:    len_next[15:8]  = rx_byte;
                        default: len_next[23:16] = rx_byte;
                    endcase
                end
                else
                begin
                    count_next = '0;
                    len_next   = sat_len;
                    rcrc_next  = '0;
                    if (full_len > {8'd0, max_len})
                    begin
                        eout.emit                 = 1'b1;
                        eout.res.kind             = KIND_OVERSIZE;
                        eout.res.frame_length     = sat_len;
                        eout.res.computed_crc     = ~crc_upd;
                        phase_next                = PH_HUNT;
                    end
                    else
                    begin
                        phase_next = (full_len == 32'd0) ? PH_CRC : PH_DATA;
                    end
                end
            end
            PH_DATA:
            begin
                crc_next              = crc_upd;
                eout.emit             = 1'b1;
                eout.res.kind         = KIND_PAYLOAD;
                eout.res.data         = rx_byte;
                eout.res.frame_length = len_reg;
                eout.res.computed_crc = ~crc_upd;
                if (count_inc >= len_reg)
                begin
                    phase_next = PH_CRC;
                    count_next = '0;
                    rcrc_next  = '0;
                end
                else
                begin
                    count_next = count_inc;
                end
            end
            PH_CRC:
            begin
                if (lane != LANE_LAST)
                begin
                    count_next = count_inc;
                    case (lane)
                        2'd0:    rcrc_next[7:0]   = rx_byte;
                        2'd1:    rcrc_next[15:8]  = rx_byte;
                        default: rcrc_next[23:16] = rx_byte;
                    endcase
                end
                else
                begin
                    eout.emit             = 1'b1;
                    eout.res.kind         = (full_rcrc == ~crc_reg) ? KIND_GOOD : KIND_BAD_CRC;
                    eout.res.frame_length = len_reg;
                    eout.res.computed_crc = ~crc_reg;
                    phase_next            = PH_HUNT;
                    count_next            = '0;
                end
            end
            default:
            begin
                if (rx_byte == START_BYTE)
                begin
                    crc_next   = crc_byte(CRC_INIT, START_BYTE);
                    len_next   = '0;
                    rcrc_next  = '0;
                    count_next = '0;
                    phase_next = PH_LEN;
                end
                else
                begin
                    eout.emit     = 1'b1;
                    eout.res.kind = KIND_STRAY;
                    eout.res.data = rx_byte;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HUNT;
            count_reg <= '0;
            len_reg   <= '0;
            crc_reg   <= CRC_INIT;
            rcrc_reg  <= '0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            count_reg <= count_next;
            len_reg   <= len_next;
            crc_reg   <= crc_next;
            rcrc_reg  <= rcrc_next;
        end
    end

endmodule

[rtl/crc32_length_frame_deframer_core.sv]
// ----------------------------------------------------------------------------
// crc32_length_frame_deframer_core
// Length-prefixed frame deframer with CRC-32 check, one byte per beat.
// Timing: a result is registered at the edge at which its byte leaves the input
//   register; a stalled result channel can hold the byte in the input register.
// Throughput: one byte per cycle while the result channel is not stalled; the
//   byte-wise CRC update and parser step lie between the input and result registers.
// Reset: parser hunts for a start byte, CRC all ones, max length 65536.
// ----------------------------------------------------------------------------
module crc32_length_frame_deframer_core
    import cldf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    cldf_rx_if.sink    rx,
    cldf_cfg_if.sink   cfg,
    cldf_res_if.source res
);

    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        out_valid_reg;
    result_t     out_reg;
    logic [23:0] max_len_reg;

    logic        advance;
    engine_out_t eout;

    assign advance  = in_valid_reg && (!out_valid_reg || res.ready);
    assign rx.ready = !in_valid_reg || advance;
    assign cfg.ready = 1'b1;

    cldf_engine u_engine (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (advance),
        .rx_byte (in_byte_reg),
        .max_len (max_len_reg),
        .eout    (eout)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            max_len_reg   <= MAX_LEN_RESET;
        end
        else
        begin
            if (rx.valid && rx.ready)
                in_valid_reg <= 1'b1;
            else if (advance)
                in_valid_reg <= 1'b0;

            if (advance)
                out_valid_reg <= eout.emit;
            else if (res.ready)
                out_valid_reg <= 1'b0;

            if (cfg.valid)
                max_len_reg <= cfg.max_payload_length;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx.valid && rx.ready)
            in_byte_reg <= rx.rx_byte;
        if (advance && eout.emit)
            out_reg <= eout.res;
    end

    assign res.valid        = out_valid_reg;
    assign res.kind         = out_reg.kind;
    assign res.data         = out_reg.data;
    assign res.frame_length = out_reg.frame_length;
    assign res.computed_crc = out_reg.computed_crc;

endmodule

[rtl/cldf_checker.sv]
// ----------------------------------------------------------------------------
// cldf_checker
// Port-level checks on the result channel of the deframer.
// ----------------------------------------------------------------------------
module cldf_checker
    import cldf_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        res_valid,
    input logic        res_ready,
    input logic [2:0]  kind,
    input logic [7:0]  data,
    input logic [23:0] frame_length,
    input logic [31:0] computed_crc
);

    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid)
        else $error("result beat dropped while stalled");

    a_hold_payload: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> $stable(kind) && $stable(data)
            && $stable(frame_length) && $stable(computed_crc))
        else $error("result payload changed while stalled");

    a_status_no_data: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (kind == KIND_GOOD || kind == KIND_BAD_CRC || kind == KIND_OVERSIZE)
            |-> data == 8'd0)
        else $error("status beat carries data");

    a_stray_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && kind == KIND_STRAY |-> frame_length == 24'd0 && computed_crc == 32'd0)
        else $error("stray beat carries frame fields");

    a_payload_len: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && kind == KIND_PAYLOAD |-> frame_length != 24'd0)
        else $error("payload beat in empty frame");

endmodule

bind crc32_length_frame_deframer_core cldf_checker u_cldf_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .res_valid    (res.valid),
    .res_ready    (res.ready),
    .kind         (res.kind),
    .data         (res.data),
    .frame_length (res.frame_length),
    .computed_crc (res.computed_crc)
);

[tb/tb_crc32_length_frame_deframer_core.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_crc32_length_frame_deframer_core
// Streams framed and unframed bytes into the deframer: good frames, CRC
// errors, oversize lengths and stray bytes, under a sweep of max-length
// settings. A scoreboard tracks parser state, predicts every result and
// checks it field by field. The sender runs in bursts and the receiver
// stalls in changing patterns, with one long hold-off that backs up the input.
// ----------------------------------------------------------------------------
module tb_crc32_length_frame_deframer_core;
    import cldf_pkg::*;

    localparam int LONG_HOLD     = 400;
    localparam int SETTLE_CYCLES = 8;
    localparam int IDLE_LIMIT    = 20000;
    localparam int RANDOM_BYTES  = 1750;
    localparam int SWEEP_STEPS   = 6;
    localparam int MAX_SHOWN     = 10;

    class deframe_scoreboard;
        logic [23:0] max_len;
        logic [1:0]  phase;
        logic [23:0] cnt;
        logic [31:0] plen;
        logic [31:0] crc;
        logic [31:0] fcs_rx;
        result_t     pending[$];
        int          failures;
        int          bytes_in;
        int          kind_seen[5];

        function new();
            max_len  = MAX_LEN_RESET;
            phase    = PH_HUNT;
            cnt      = '0;
            plen     = '0;
            crc      = CRC_INIT;
            fcs_rx   = '0;
            failures = 0;
            bytes_in = 0;
            foreach (kind_seen[k])
                kind_seen[k] = 0;
        endfunction

        static function logic [31:0] crc_step(logic [31:0] c, logic [7:0] b);
            logic [31:0] r;
            r = c ^ {24'd0, b};
            repeat (8)
                r = (r >> 1) ^ (CRC_POLY & {32{r[0]}});
            return r;
        endfunction

        function result_t frame_result(logic [2:0] k);
            result_t r;
            r.kind         = k;
            r.data         = '0;
            r.frame_length = (plen > {8'd0, LEN_SAT}) ? LEN_SAT : plen[23:0];
            r.computed_crc = ~crc;
            return r;
        endfunction

        function void take_byte(logic [7:0] b);
            result_t r;
            bit      hit;
            r   = '0;
            hit = 1'b0;
            bytes_in++;
            case (phase)
                PH_LEN:
                begin
                    crc  = crc_step(crc, b);
                    plen = plen | ({24'd0, b} << (8 * cnt[1:0]));
                    cnt  = cnt + 24'd1;
                    if (cnt == 24'd4)
                    begin
                        cnt = '0;
                        if (plen > {8'd0, max_len})
                        begin
                            r     = frame_result(KIND_OVERSIZE);
                            hit   = 1'b1;
                            phase = PH_HUNT;
                        end
                        else
                        begin
                            phase  = (plen == 32'd0) ? PH_CRC : PH_DATA;
                            fcs_rx = '0;
                        end
                    end
                end
                PH_DATA:
                begin
                    crc    = crc_step(crc, b);
                    r      = frame_result(KIND_PAYLOAD);
                    r.data = b;
                    hit    = 1'b1;
                    cnt    = cnt + 24'd1;
                    if ({8'd0, cnt} >= plen)
                    begin
                        phase  = PH_CRC;
                        cnt    = '0;
                        fcs_rx = '0;
                    end
                end
                PH_CRC:
                begin
                    fcs_rx = fcs_rx | ({24'd0, b} << (8 * cnt[1:0]));
                    cnt    = cnt + 24'd1;
                    if (cnt == 24'd4)
                    begin
                        r     = frame_result((fcs_rx == ~crc) ? KIND_GOOD : KIND_BAD_CRC);
                        hit   = 1'b1;
                        phase = PH_HUNT;
                        cnt   = '0;
                    end
                end
                default:
                begin
                    if (b == START_BYTE)
                    begin
                        crc    = crc_step(CRC_INIT, b);
                        plen   = '0;
                        fcs_rx = '0;
                        cnt    = '0;
                        phase  = PH_LEN;
                    end
                    else
                    begin
                        phase  = PH_HUNT;
                        r.kind = KIND_STRAY;
                        r.data = b;
                        hit    = 1'b1;
                    end
                end
            endcase
            if (hit)
                pending.push_back(r);
        endfunction

        function void note_miss(string what, result_t want, result_t got);
            failures++;
            if (failures <= MAX_SHOWN)
                $display({"[%0t] %s: expected kind %0d data %h len %h crc %h, ",
                          "got kind %0d data %h len %h crc %h"},
                         $realtime, what, want.kind, want.data, want.frame_length,
                         want.computed_crc, got.kind, got.data, got.frame_length,
                         got.computed_crc);
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (pending.size() == 0)
            begin
                note_miss("unexpected beat", '0, got);
                return;
            end
            want = pending.pop_front();
            if (got.kind !== want.kind || got.data !== want.data ||
                got.frame_length !== want.frame_length ||
                got.computed_crc !== want.computed_crc)
                note_miss("mismatch", want, got);
            else
                kind_seen[want.kind]++;
        endfunction
    endclass

    logic clk;
    logic rst_n;

    cldf_rx_if  rx();
    cldf_cfg_if cfg();
    cldf_res_if res();

    crc32_length_frame_deframer_core uut (
        .clk   (clk),
        .rst_n (rst_n),
        .rx    (rx),
        .cfg   (cfg),
        .res   (res)
    );

    deframe_scoreboard sb = new();
    logic [7:0]        byte_q[$];
    logic [23:0]       max_len_now = MAX_LEN_RESET;
    bit                hold_request = 1'b0;
    int                settings_used = 1;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #4ms;
        $display("Some tests failed");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rx.valid && rx.ready)
                sb.take_byte(rx.rx_byte);
            if (res.valid && res.ready)
                sb.check_result({res.kind, res.data, res.frame_length, res.computed_crc});
        end
    end

    // result sink: changing stall patterns plus a single long hold-off
    initial
    begin : sink_pacing
        int mode;
        int span;
        int period;
        int tick;
        int hold_left;
        mode      = 0;
        span      = 0;
        period    = 2;
        tick      = 0;
        hold_left = 0;
        res.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left    = LONG_HOLD;
            end
            if (span == 0)
            begin
                mode   = $urandom_range(0, 3);
                span   = $urandom_range(16, 160);
                period = $urandom_range(2, 6);
            end
            span--;
            tick++;
            if (hold_left > 0)
            begin
                hold_left--;
                res.ready <= 1'b0;
            end
            else
            begin
                case (mode)
                    0:       res.ready <= 1'b1;
                    1:       res.ready <= ($urandom_range(0, 3) != 0);
                    2:       res.ready <= ($urandom_range(0, 3) == 0);
                    default: res.ready <= ((tick % period) != 0);
                endcase
            end
        end
    end

    function automatic void add_crc_byte(inout logic [31:0] c, input logic [7:0] b);
        byte_q.push_back(b);
        c = deframe_scoreboard::crc_step(c, b);
    endfunction

    // start byte, length, then payload and FCS unless oversize
    task automatic queue_frame(input logic [31:0] len, input bit bad_crc, input int start_at);
        logic [31:0] c;
        logic [31:0] fcs;
        logic [7:0]  b;
        int          i;
        c = CRC_INIT;
        add_crc_byte(c, START_BYTE);
        for (i = 0; i < 4; i++)
            add_crc_byte(c, len[8*i +: 8]);
        if (len > {8'd0, max_len_now})
            return;
        for (i = 0; i < len; i++)
        begin
            if (i == start_at || $urandom_range(0, 9) == 0)
                b = START_BYTE;
            else
                b = 8'($urandom_range(0, 255));
            add_crc_byte(c, b);
        end
        fcs = ~c;
        if (bad_crc)
            fcs = fcs ^ (32'd1 << $urandom_range(0, 31));
        for (i = 0; i < 4; i++)
            byte_q.push_back(fcs[8*i +: 8]);
    endtask

    task automatic queue_random_item();
        int          sel;
        int          cap;
        int          n;
        logic [31:0] len;
        logic [7:0]  b;
        sel = $urandom_range(0, 99);
        if (sel < 74)
        begin
            if ($urandom_range(0, 19) < 15)
                cap = 16;
            else
                cap = ($urandom_range(0, 3) != 0) ? 48 : 300;
            if (cap > max_len_now)
                cap = int'(max_len_now);
            len = ($urandom_range(0, 4) == 0) ? cap : $urandom_range(0, cap);
            queue_frame(len, sel >= 62, -1);
        end
        else if (sel < 86)
        begin
            if (max_len_now == LEN_SAT)
                len = $urandom_range(0, 1) ? 32'hFFFF_FFFF
                                           : $urandom_range(32'h0100_0000, 32'hFFFF_FFFF);
            else
            begin
                case ($urandom_range(0, 2))
                    0:       len = {8'd0, max_len_now} + 32'd1;
                    1:       len = $urandom_range({8'd0, max_len_now} + 32'd1, {8'd0, LEN_SAT});
                    default: len = $urandom() | 32'h0100_0000;
                endcase
            end
            queue_frame(len, 1'b0, -1);
        end
        else
        begin
            n = $urandom_range(1, 4);
            repeat (n)
            begin
                do
                    b = 8'($urandom_range(0, 255));
                while (b == START_BYTE);
                byte_q.push_back(b);
            end
        end
    endtask

    // called at a falling edge; returns at a falling edge
    task automatic send_bytes();
        int burst;
        int gap;
        burst = 0;
        while (byte_q.size() > 0)
        begin
            if (burst == 0)
            begin
                burst = $urandom_range(1, 24);
                gap   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                if (gap > 0)
                begin
                    rx.valid <= 1'b0;
                    repeat (gap) @(negedge clk);
                end
            end
            rx.valid   <= 1'b1;
            rx.rx_byte <= byte_q.pop_front();
            do
                @(posedge clk);
            while (!rx.ready);
            @(negedge clk);
            burst--;
        end
        rx.valid <= 1'b0;
    endtask

    task automatic wait_idle();
        int waited;
        waited = 0;
        while (sb.pending.size() != 0 && waited < IDLE_LIMIT)
        begin
            @(negedge clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic set_max_len(input logic [23:0] v);
        cfg.valid              <= 1'b1;
        cfg.max_payload_length <= v;
        do
            @(posedge clk);
        while (!cfg.ready);
        sb.max_len  = v;
        max_len_now = v;
        settings_used++;
        @(negedge clk);
        cfg.valid <= 1'b0;
    endtask

    initial
    begin : stimulus
        logic [23:0] sweep [0:SWEEP_STEPS-1];
        int          p;
        rx.valid               = 1'b0;
        rx.rx_byte             = '0;
        cfg.valid              = 1'b0;
        cfg.max_payload_length = '0;
        rst_n                  = 1'b0;
        sweep = '{24'd0, LEN_SAT, 24'd12, 24'd1, 24'd300, MAX_LEN_RESET};
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // stray bytes, empty frame, start byte in payload with bad FCS,
        // saturated and in-range oversize lengths
        byte_q.push_back(8'h00);
        byte_q.push_back(8'hFF);
        queue_frame(32'd0, 1'b0, -1);
        queue_frame(32'd3, 1'b1, 0);
        queue_frame(32'hFFFF_FFFF, 1'b0, -1);
        queue_frame(32'd65537, 1'b0, -1);
        send_bytes();
        wait_idle();

        for (p = 0; p <= SWEEP_STEPS; p++)
        begin
            if (p > 0)
                set_max_len(sweep[p-1]);
            if (p == 2)
                hold_request = 1'b1;
            while (byte_q.size() < RANDOM_BYTES / (SWEEP_STEPS + 1))
                queue_random_item();
            send_bytes();
            wait_idle();
        end

        if (sb.pending.size() != 0)
        begin
            $display("%0d expected beats never arrived", sb.pending.size());
            sb.failures += sb.pending.size();
        end
        $display("Run covered %0d input bytes across %0d max-length settings", sb.bytes_in,
                 settings_used);
        $display("Matched: %0d payload, %0d good, %0d crc error, %0d oversize, %0d stray",
                 sb.kind_seen[KIND_PAYLOAD], sb.kind_seen[KIND_GOOD],
                 sb.kind_seen[KIND_BAD_CRC], sb.kind_seen[KIND_OVERSIZE],
                 sb.kind_seen[KIND_STRAY]);
        if (sb.failures == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
